// ===== hw/rtl/shlex_pkg.sv =====
`default_nettype none

package shlex_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_WEND = 2'd1,
    KIND_OP   = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  // operator tokens
  typedef enum logic [2:0] {
    OP_PIPE   = 3'd0,
    OP_SEMI   = 3'd1,
    OP_AMP    = 3'd2,
    OP_LESS   = 3'd3,
    OP_GREAT  = 3'd4,
    OP_TWOGT  = 3'd5
  } op_t;

  // quoting mode; the unused code behaves as plain
  typedef enum logic [1:0] {
    Q_PLAIN  = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2,
    Q_SPARE  = 2'd3
  } quote_t;

  // pending mark; the unused code behaves as nothing pending
  typedef enum logic [1:0] {
    P_NONE  = 2'd0,
    P_BSL   = 2'd1,
    P_TWO   = 2'd2,
    P_SPARE = 2'd3
  } pend_t;

  localparam int MaxResults = 3;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int IdxW       = $clog2(MaxResults);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LESS   = 8'h3c;
  localparam logic [7:0] CH_GREAT  = 8'h3e;
  localparam logic [7:0] CH_BSL    = 8'h5c;
  localparam logic [7:0] CH_PIPE   = 8'h7c;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    op_t        op;
  } res_t;

  function automatic res_t make_res(kind_t kind, logic [7:0] ch, op_t op);
    res_t r;
    r.kind = kind;
    r.ch   = (kind == KIND_CHAR) ? ch : CH_NUL;
    r.op   = (kind == KIND_OP) ? op : OP_PIPE;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/shell_command_lexer_core.sv =====
`default_nettype none

// streaming shell command-line lexer: one byte of a line per input transfer, byte 0 ends
// the line. quotes are stripped, backslash escapes resolved, and the line split into word
// characters, word-end marks, operator tokens (| ; & < > 2>) and a line-done mark. each
// byte gives 0 to 3 results; the last result of a byte carries tlast. a byte is held in an
// input register, decoded combinationally against the lexer state and written as a whole
// bundle of results into the result register, which drains one result per output transfer.
// a byte is taken every cycle while bytes give at most one result each and m_tready holds;
// a byte with more results holds the output until all drain; the input stalls behind it.
module shell_command_lexer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // [7:0] char_out, [10:8] op_code, [15:11] zero
  output      logic [1:0]  m_tuser,   // [1:0] kind
  output      logic        m_tlast    // last result caused by the byte
);

  localparam int CntW = shlex_pkg::CntW;
  localparam int IdxW = shlex_pkg::IdxW;

  // input register
  logic       in_full;
  logic [7:0] in_char;

  // lexer state
  shlex_pkg::quote_t quote_mode, quote_mode_next;
  shlex_pkg::pend_t  pending, pending_next;
  logic              word_open, word_open_next;

  // result bundle register
  shlex_pkg::res_t  bundle [shlex_pkg::MaxResults];
  logic [CntW-1:0]  bcnt;
  logic [IdxW-1:0]  bptr;

  // decoded results of the byte in the input register
  shlex_pkg::res_t  res [shlex_pkg::MaxResults];
  logic [CntW-1:0]  rcnt;
  logic             line_end;

  logic take, take_last, load, accept;

  // output side
  assign m_tvalid  = (bcnt != '0);
  assign take      = m_tvalid && m_tready;
  assign m_tlast   = ({{(CntW-IdxW){1'b0}}, bptr} == bcnt - CntW'(1));
  assign take_last = take && m_tlast;

  // a byte moves into the bundle once the previous bundle is gone or leaving
  assign load     = in_full && (!m_tvalid || take_last);
  assign s_tready = !in_full || load;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    shlex_pkg::res_t cur;
    cur      = bundle[bptr];
    m_tdata  = {5'b0, cur.op, cur.ch};
    m_tuser  = cur.kind;
  end

  // one-byte decode, following the order in which results arise
  always_comb begin
    logic       quoted, do_plain, do_quoted;
    logic [7:0] c, qc;
    c               = in_char;
    quoted          = (quote_mode == shlex_pkg::Q_SINGLE) ||
                      (quote_mode == shlex_pkg::Q_DOUBLE);
    qc              = (quote_mode == shlex_pkg::Q_SINGLE) ? shlex_pkg::CH_SQUOTE
                                                          : shlex_pkg::CH_DQUOTE;
    quote_mode_next = quote_mode;
    pending_next    = shlex_pkg::P_NONE;
    word_open_next  = word_open;
    rcnt            = '0;
    line_end        = 1'b0;
    do_plain        = 1'b0;
    do_quoted       = 1'b0;
    for (int i = 0; i < shlex_pkg::MaxResults; i++) begin
      res[i] = shlex_pkg::make_res(shlex_pkg::KIND_DONE, shlex_pkg::CH_NUL,
                                   shlex_pkg::OP_PIPE);
    end

    if (!quoted) begin
      if (pending == shlex_pkg::P_BSL) begin
        // escaped byte, or a trailing backslash at end of line
        if (c == shlex_pkg::CH_NUL) begin
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_CHAR,
                                  shlex_pkg::CH_BSL, shlex_pkg::OP_PIPE);
          rcnt           = rcnt + CntW'(1);
          word_open_next = 1'b1;
          line_end       = 1'b1;
        end else begin
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_CHAR, c,
                                  shlex_pkg::OP_PIPE);
          rcnt           = rcnt + CntW'(1);
          word_open_next = 1'b1;
        end
      end else if (pending == shlex_pkg::P_TWO) begin
        if (c == shlex_pkg::CH_GREAT) begin
          if (word_open_next) begin
            res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_WEND,
                                    shlex_pkg::CH_NUL, shlex_pkg::OP_PIPE);
            rcnt           = rcnt + CntW'(1);
            word_open_next = 1'b0;
          end
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_OP,
                                  shlex_pkg::CH_NUL, shlex_pkg::OP_TWOGT);
          rcnt = rcnt + CntW'(1);
        end else begin
          // the held '2' was an ordinary character
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_CHAR,
                                  shlex_pkg::CH_TWO, shlex_pkg::OP_PIPE);
          rcnt           = rcnt + CntW'(1);
          word_open_next = 1'b1;
          do_plain       = 1'b1;
        end
      end else begin
        do_plain = 1'b1;
      end
    end else begin
      if (pending == shlex_pkg::P_BSL) begin
        if (c == qc) begin
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_CHAR, qc,
                                  shlex_pkg::OP_PIPE);
          rcnt           = rcnt + CntW'(1);
          word_open_next = 1'b1;
        end else begin
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_CHAR,
                                  shlex_pkg::CH_BSL, shlex_pkg::OP_PIPE);
          rcnt           = rcnt + CntW'(1);
          word_open_next = 1'b1;
          do_quoted      = 1'b1;
        end
      end else begin
        do_quoted = 1'b1;
      end
    end

    if (do_plain) begin
      if (c == shlex_pkg::CH_NUL) begin
        line_end = 1'b1;
      end else if (c == shlex_pkg::CH_SPACE || c == shlex_pkg::CH_TAB) begin
        if (word_open_next) begin
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_WEND,
                                  shlex_pkg::CH_NUL, shlex_pkg::OP_PIPE);
          rcnt           = rcnt + CntW'(1);
          word_open_next = 1'b0;
        end
      end else if (c == shlex_pkg::CH_SQUOTE) begin
        quote_mode_next = shlex_pkg::Q_SINGLE;
      end else if (c == shlex_pkg::CH_DQUOTE) begin
        quote_mode_next = shlex_pkg::Q_DOUBLE;
      end else if (c == shlex_pkg::CH_BSL) begin
        pending_next = shlex_pkg::P_BSL;
      end else if (c == shlex_pkg::CH_TWO) begin
        pending_next = shlex_pkg::P_TWO;
      end else if (c == shlex_pkg::CH_PIPE || c == shlex_pkg::CH_SEMI ||
                   c == shlex_pkg::CH_AMP  || c == shlex_pkg::CH_LESS ||
                   c == shlex_pkg::CH_GREAT) begin
        if (word_open_next) begin
          res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_WEND,
                                  shlex_pkg::CH_NUL, shlex_pkg::OP_PIPE);
          rcnt           = rcnt + CntW'(1);
          word_open_next = 1'b0;
        end
        case (c)
          shlex_pkg::CH_PIPE: res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(
                                shlex_pkg::KIND_OP, shlex_pkg::CH_NUL, shlex_pkg::OP_PIPE);
          shlex_pkg::CH_SEMI: res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(
                                shlex_pkg::KIND_OP, shlex_pkg::CH_NUL, shlex_pkg::OP_SEMI);
          shlex_pkg::CH_AMP:  res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(
                                shlex_pkg::KIND_OP, shlex_pkg::CH_NUL, shlex_pkg::OP_AMP);
          shlex_pkg::CH_LESS: res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(
                                shlex_pkg::KIND_OP, shlex_pkg::CH_NUL, shlex_pkg::OP_LESS);
          default:            res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(
                                shlex_pkg::KIND_OP, shlex_pkg::CH_NUL, shlex_pkg::OP_GREAT);
        endcase
        rcnt = rcnt + CntW'(1);
      end else begin
        res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_CHAR, c,
                                shlex_pkg::OP_PIPE);
        rcnt           = rcnt + CntW'(1);
        word_open_next = 1'b1;
      end
    end

    if (do_quoted) begin
      if (c == shlex_pkg::CH_NUL) begin
        line_end = 1'b1;
      end else if (c == shlex_pkg::CH_BSL) begin
        pending_next = shlex_pkg::P_BSL;
      end else if (c == qc) begin
        quote_mode_next = shlex_pkg::Q_PLAIN;
      end else begin
        res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_CHAR, c,
                                shlex_pkg::OP_PIPE);
        rcnt           = rcnt + CntW'(1);
        word_open_next = 1'b1;
      end
    end

    // end of line closes any open word, even inside an unterminated quote
    if (line_end) begin
      if (word_open_next) begin
        res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_WEND,
                                shlex_pkg::CH_NUL, shlex_pkg::OP_PIPE);
        rcnt = rcnt + CntW'(1);
      end
      res[rcnt[IdxW-1:0]] = shlex_pkg::make_res(shlex_pkg::KIND_DONE,
                              shlex_pkg::CH_NUL, shlex_pkg::OP_PIPE);
      rcnt            = rcnt + CntW'(1);
      quote_mode_next = shlex_pkg::Q_PLAIN;
      pending_next    = shlex_pkg::P_NONE;
      word_open_next  = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_char <= s_tdata;
    end
  end

  // lexer state advances as the byte's results are committed
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= shlex_pkg::Q_PLAIN;
      pending    <= shlex_pkg::P_NONE;
      word_open  <= 1'b0;
    end else if (load) begin
      quote_mode <= quote_mode_next;
      pending    <= pending_next;
      word_open  <= word_open_next;
    end
  end

  // result bundle control
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
      bptr <= '0;
    end else if (load) begin
      bcnt <= rcnt;
      bptr <= '0;
    end else if (take_last) begin
      bcnt <= '0;
      bptr <= '0;
    end else if (take) begin
      bptr <= bptr + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < shlex_pkg::MaxResults; i++) begin
        bundle[i] <= res[i];
      end
    end
  end

  // the read pointer never runs past the results held
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (bcnt != '0) |-> ({{(CntW-IdxW){1'b0}}, bptr} < bcnt))
    else $error("bundle read pointer beyond held results");

  // a new bundle only replaces one that is empty or finishing
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (bcnt == '0 || take_last))
    else $error("result bundle overwritten before drained");

  // line done is always the final result of its byte
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == shlex_pkg::KIND_DONE) |-> m_tlast)
    else $error("line done not marked last");

  // end of line leaves the lexer at its reset state
  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (load && line_end) |=> (quote_mode == shlex_pkg::Q_PLAIN &&
                            pending == shlex_pkg::P_NONE && !word_open))
    else $error("lexer state not cleared at end of line");

endmodule

`default_nettype wire

// ===== tb/shell_command_lexer_core_test.sv =====
module shell_command_lexer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import shlex_pkg::*;

  // one expected result of the lexer
  typedef struct {
    kind_t      kind;
    logic [7:0] ch;
    op_t        op;
    logic       last;
  } tok_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct {
    logic [7:0] ch;
    logic       typed;
    kind_t      kind;
    logic [7:0] ech;
    op_t        eop;
  } dir_row_t;

  localparam int NumDir      = 30;
  localparam int PhaseItems  = 42;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // idling in percent, changed per phase
  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  int          fails      = 0;

  // lexer state as the testbench sees it
  quote_t     lex_quote;
  pend_t      lex_pend;
  logic       lex_word;
  tok_t       lex_out[$];
  tok_t       expected_q[$];

  dir_row_t   dir_rows [NumDir];

  shell_command_lexer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- lexer predictor

  function automatic void tok_push(kind_t k, logic [7:0] c, op_t o);
    tok_t t;
    t.kind = k;
    t.ch   = (k == KIND_CHAR) ? c : CH_NUL;
    t.op   = (k == KIND_OP) ? o : OP_PIPE;
    t.last = 1'b0;
    lex_out.push_back(t);
  endfunction

  function automatic void word_char(logic [7:0] c);
    tok_push(KIND_CHAR, c, OP_PIPE);
    lex_word = 1'b1;
  endfunction

  function automatic void word_close();
    if (lex_word) begin
      tok_push(KIND_WEND, CH_NUL, OP_PIPE);
      lex_word = 1'b0;
    end
  endfunction

  function automatic void line_end();
    word_close();
    tok_push(KIND_DONE, CH_NUL, OP_PIPE);
    lex_quote = Q_PLAIN;
    lex_pend  = P_NONE;
    lex_word  = 1'b0;
  endfunction

  function automatic void op_token(op_t o);
    word_close();
    tok_push(KIND_OP, CH_NUL, o);
  endfunction

  // byte outside quotes with nothing pending
  function automatic void plain_char(logic [7:0] c);
    case (c)
      CH_NUL:           line_end();
      CH_SPACE, CH_TAB: word_close();
      CH_SQUOTE:        lex_quote = Q_SINGLE;
      CH_DQUOTE:        lex_quote = Q_DOUBLE;
      CH_BSL:           lex_pend = P_BSL;
      CH_TWO:           lex_pend = P_TWO;
      CH_PIPE:          op_token(OP_PIPE);
      CH_SEMI:          op_token(OP_SEMI);
      CH_AMP:           op_token(OP_AMP);
      CH_LESS:          op_token(OP_LESS);
      CH_GREAT:         op_token(OP_GREAT);
      default:          word_char(c);
    endcase
  endfunction

  function automatic void quoted_char(logic [7:0] c, logic [7:0] q);
    if (c == CH_NUL) begin
      line_end();
    end else if (c == CH_BSL) begin
      lex_pend = P_BSL;
    end else if (c == q) begin
      lex_quote = Q_PLAIN;
    end else begin
      word_char(c);
    end
  endfunction

  // results of one accepted byte land in lex_out, last one flagged
  function automatic void lex_char(logic [7:0] c);
    logic       quoted;
    logic [7:0] q;
    pend_t      was;
    lex_out.delete();
    quoted   = (lex_quote == Q_SINGLE) || (lex_quote == Q_DOUBLE);
    q        = (lex_quote == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
    was      = lex_pend;
    lex_pend = P_NONE;
    if (!quoted) begin
      if (was == P_BSL) begin
        // escaped byte, or a trailing backslash at end of line
        if (c == CH_NUL) begin
          word_char(CH_BSL);
          line_end();
        end else begin
          word_char(c);
        end
      end else if (was == P_TWO) begin
        if (c == CH_GREAT) begin
          op_token(OP_TWOGT);
        end else begin
          word_char(CH_TWO);
          plain_char(c);
        end
      end else begin
        plain_char(c);
      end
    end else begin
      // a pending two has no meaning inside quotes
      if (was == P_BSL) begin
        if (c == q) begin
          word_char(q);
        end else begin
          word_char(CH_BSL);
          quoted_char(c, q);
        end
      end else begin
        quoted_char(c, q);
      end
    end
    if (lex_out.size() > 0) lex_out[lex_out.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // offer one byte, hold it until the transfer, then record what it should give
  task automatic send_char(input logic [7:0] c, input logic typed, input tok_t typed_tok);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    lex_char(c);
    if (typed) begin
      expected_q.push_back(typed_tok);
    end else begin
      foreach (lex_out[i]) expected_q.push_back(lex_out[i]);
    end
  endtask

  // sender holds off until every expected result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // biased byte: mostly shell-like text, some noise and early line ends
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 40) return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
    if (r < 48) return ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
    if (r < 55) return CH_BSL;
    if (r < 63) return CH_TWO;
    if (r < 76) begin
      case ($urandom_range(0, 4))
        0:       return CH_PIPE;
        1:       return CH_SEMI;
        2:       return CH_AMP;
        3:       return CH_LESS;
        default: return CH_GREAT;
      endcase
    end
    if (r < 80) return CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // whole lines of random content until the phase has enough bytes
  task automatic random_lines(input int n);
    tok_t dummy;
    int   sent;
    int   len;
    dummy = '{KIND_CHAR, CH_NUL, OP_PIPE, 1'b0};
    sent  = 0;
    while (sent < n) begin
      len = $urandom_range(0, 10);
      for (int k = 0; k < len; k++) begin
        send_char(pick_char(), 1'b0, dummy);
        sent++;
      end
      send_char(CH_NUL, 1'b0, dummy);
      sent++;
    end
  endtask

  initial begin
    tok_t t;

    // directed table: typed rows are plain to read, the rest goes through the predictor
    dir_rows = '{
      '{CH_NUL,    1'b1, KIND_DONE, CH_NUL, OP_PIPE},  // empty line
      '{CH_PIPE,   1'b1, KIND_OP,   CH_NUL, OP_PIPE},
      '{CH_SEMI,   1'b1, KIND_OP,   CH_NUL, OP_SEMI},
      '{CH_AMP,    1'b1, KIND_OP,   CH_NUL, OP_AMP},
      '{CH_LESS,   1'b1, KIND_OP,   CH_NUL, OP_LESS},
      '{CH_GREAT,  1'b1, KIND_OP,   CH_NUL, OP_GREAT},
      '{8'hff,     1'b1, KIND_CHAR, 8'hff,  OP_PIPE},  // top byte value
      '{CH_TAB,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // tab closes the word
      '{8'h01,     1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_TWO,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_GREAT,  1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // 2> after an open word
      '{CH_TWO,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_SEMI,   1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // lone 2 then operator, three results
      '{CH_SQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_BSL,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_SQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // escaped closing quote
      '{CH_BSL,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{8'h71,     1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // backslash kept inside quotes
      '{CH_SQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_DQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_DQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_SPACE,  1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_DQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_BSL,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_NUL,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // line ends inside an open quote
      '{CH_BSL,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_NUL,    1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // trailing backslash
      '{CH_SQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},
      '{CH_SQUOTE, 1'b0, KIND_CHAR, CH_NUL, OP_PIPE},  // empty quotes open no word
      '{CH_NUL,    1'b1, KIND_DONE, CH_NUL, OP_PIPE}
    };

    lex_quote = Q_PLAIN;
    lex_pend  = P_NONE;
    lex_word  = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // phase 0: no idling on either side
    send_idle  = 0;
    recv_stall = 0;
    foreach (dir_rows[i]) begin
      t = '{dir_rows[i].kind, dir_rows[i].ech, dir_rows[i].eop, 1'b1};
      send_char(dir_rows[i].ch, dir_rows[i].typed, t);
    end
    random_lines(PhaseItems);
    drain();

    // phase 1: sender idle about half the time
    send_idle = 51;
    random_lines(PhaseItems);
    drain();

    // phase 2: receiver stalling about half the time
    send_idle  = 0;
    recv_stall = 51;
    random_lines(PhaseItems);
    drain();

    // phase 3: light idling on both sides
    send_idle  = 18;
    recv_stall = 18;
    random_lines(PhaseItems);
    drain();

    repeat (20) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // random back-pressure and the field-by-field check of each result transfer
  always @(posedge clk) begin
    tok_t e;
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d data %h", m_tuser, m_tdata);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (m_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, m_tuser);
          fails++;
        end
        if (m_tdata[7:0] !== e.ch) begin
          $error("char_out: expected %h, got %h", e.ch, m_tdata[7:0]);
          fails++;
        end
        if (m_tdata[10:8] !== e.op) begin
          $error("op_code: expected %0d, got %0d", e.op, m_tdata[10:8]);
          fails++;
        end
        if (m_tdata[15:11] !== 5'd0) begin
          $error("tdata padding: expected 0, got %h", m_tdata[15:11]);
          fails++;
        end
        if (m_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_tlast);
          fails++;
        end
      end
    end
  end

  // run guard, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
